// File: sv/aprw_pkg.sv
`timescale 1ns / 1ps

package aprw_pkg;

    localparam int PULSE_W       = 15;
    localparam int IVL_W         = 24;
    localparam int TIME_W        = 48;
    localparam int DELTA_W       = 16;
    localparam int PULSE_SUM_W   = 20;
    localparam int TIME_SUM_W    = 29;
    localparam int MAX_LEN_W     = 5;
    localparam int MAX_DELAY_W   = 24;
    localparam int RES_W         = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 24;

    localparam int DEFAULT_DEPTH = 32;

    localparam int TRIM_SCALE    = 18;
    localparam int RES_SCALE     = 1000;
    localparam int MIN_KEEP      = 2;

    localparam logic [MAX_LEN_W-1:0]   MAX_LEN_RST   = 5'd16;
    localparam logic [MAX_DELAY_W-1:0] MAX_DELAY_RST = 24'd50000;
    localparam logic [RES_W-1:0]       RES_RST       = 16'd10;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DELAY  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESOLUTION = 2'd2;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic signed [DELTA_W-1:0] pulse_delta;
        logic [TIME_W-1:0]         sample_time;
    } t_in_item;

    typedef struct packed {
        logic [PULSE_SUM_W-1:0] pulse_sum;
        logic [TIME_SUM_W-1:0]  time_sum;
    } t_out_item;

    typedef struct packed {
        logic [PULSE_W-1:0] pulses;
        logic [IVL_W-1:0]   interval;
    } t_entry;

endpackage

// File: sv/adaptive_pulse_rate_window_core.sv
`timescale 1ns / 1ps

// Channel | Direction | Signals                          | Beat
// in      | sink      | i_in_valid, o_in_ready, i_in_data  | one sample or clear request
// out     | source    | o_out_valid, i_out_ready, o_out_data | both window sums
// cfg     | sink      | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | one register write
//
// After acceptance a sample passes S_AGE, dropping entries for age one per cycle, and S_PUSH.
// Trimming then runs S_TRIM_MUL and S_TRIM_CMP (a multiply and a compare) for each entry it
// trims, and stops in S_TRIM_MUL on the entry count or in S_TRIM_CMP on the threshold test.
// A clear goes straight to S_OUT. Every drop uses the single read port of the window memory.
// Reset is synchronous and active low; it clears the window bookkeeping but not the memory.
// The block returns to idle once its result sits in the output register, so a new item is taken
// while that beat waits; the next result then holds the block in its output state until the
// earlier beat is accepted.

module adaptive_pulse_rate_window_core
    import aprw_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SW    = CW + 1;
    localparam int PW    = (PULSE_W + AW > PULSE_SUM_W) ? PULSE_W + AW : PULSE_SUM_W;
    localparam int TW    = (IVL_W + AW > TIME_SUM_W) ? IVL_W + AW : TIME_SUM_W;
    localparam int LW    = (CW > MAX_LEN_W) ? CW : MAX_LEN_W;
    localparam int AGE_W = TIME_W + 2;
    localparam int IV_W  = TIME_W + 1;
    localparam int MW    = PW + TW;
    localparam int CMP_W = MW + 5;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_AGE      = 3'd1;
    localparam logic [2:0] S_PUSH     = 3'd2;
    localparam logic [2:0] S_TRIM_MUL = 3'd3;
    localparam logic [2:0] S_TRIM_CMP = 3'd4;
    localparam logic [2:0] S_OUT      = 3'd5;

    t_entry r_mem [WINDOW_DEPTH];
    t_entry r_rd;

    logic [2:0]             r_state, n_state;
    logic [AW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_count, n_count;
    logic [PW-1:0]          r_ptot, n_ptot;
    logic [TW-1:0]          r_itot, n_itot;
    logic [TIME_W-1:0]      r_last, n_last;
    logic                   r_first, n_first;
    t_in_item               r_item, n_item;
    logic [MW-1:0]          r_prod, n_prod;
    logic                   r_too_long, n_too_long;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;
    logic [MAX_LEN_W-1:0]   r_max_len;
    logic [MAX_DELAY_W-1:0] r_max_delay;
    logic [RES_W-1:0]       r_res;

    logic                   w_we;
    logic [AW-1:0]          w_addr;
    t_entry                 w_wdata;
    logic [AW-1:0]          w_head_inc;
    logic [SW-1:0]          w_slot_sum;
    logic [AW-1:0]          w_slot;
    logic [AGE_W-1:0]       w_age;
    logic [AGE_W-1:0]       w_limit;
    logic [IV_W-1:0]        w_ivl;
    logic                   w_ivl_ok;
    logic                   w_delta_pos;
    logic [PW-1:0]          w_p;
    logic [TW-1:0]          w_t;
    logic [CMP_W-1:0]       w_scaled;
    logic [CMP_W-1:0]       w_thresh;
    logic                   w_fine;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_head_inc = (r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_slot_sum = SW'(r_head) + SW'(r_count);
    assign w_slot     = (w_slot_sum >= SW'(WINDOW_DEPTH))
                        ? AW'(w_slot_sum - SW'(WINDOW_DEPTH)) : AW'(w_slot_sum);

    // Distance from the start of the window to now; signed, time may run backwards.
    assign w_age   = AGE_W'(r_item.sample_time) - AGE_W'(r_last) + AGE_W'(r_itot);
    assign w_limit = AGE_W'({r_max_delay, 1'b0});

    assign w_ivl       = IV_W'(r_item.sample_time) - IV_W'(r_last);
    assign w_ivl_ok    = !w_ivl[IV_W-1] && (w_ivl != '0) && (w_ivl < IV_W'(r_max_delay));
    assign w_delta_pos = !r_item.pulse_delta[DELTA_W-1] && (r_item.pulse_delta != '0);

    assign w_p      = r_ptot - PW'(r_rd.pulses);
    assign w_t      = r_itot - TW'(r_rd.interval);
    assign w_scaled = (CMP_W'(r_prod) << 4) + (CMP_W'(r_prod) << 1);
    assign w_thresh = CMP_W'(r_res) * CMP_W'(RES_SCALE);
    assign w_fine   = (w_scaled >= w_thresh);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_ptot      = r_ptot;
        n_itot      = r_itot;
        n_last      = r_last;
        n_first     = r_first;
        n_item      = r_item;
        n_prod      = r_prod;
        n_too_long  = r_too_long;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_addr      = w_slot;
        w_wdata     = '{pulses: r_item.pulse_delta[PULSE_W-1:0],
                        interval: w_ivl[IVL_W-1:0]};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_data;
                    if (i_in_data.req_type == REQ_CLEAR) begin
                        n_head  = '0;
                        n_count = '0;
                        n_ptot  = '0;
                        n_itot  = '0;
                        n_first = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        if (r_first) begin
                            n_last  = i_in_data.sample_time;
                            n_first = 1'b0;
                        end
                        n_state = S_AGE;
                    end
                end
            end
            S_AGE: begin
                if ((r_count != '0) && ($signed(w_age) > $signed(w_limit))) begin
                    n_head  = w_head_inc;
                    n_count = r_count - 1'b1;
                    n_ptot  = r_ptot - PW'(r_rd.pulses);
                    n_itot  = r_itot - TW'(r_rd.interval);
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (w_delta_pos) begin
                    if (w_ivl_ok) begin
                        w_we = 1'b1;
                        if (r_count == CW'(WINDOW_DEPTH)) begin
                            // A full window loses its oldest entry; the new one takes its slot.
                            n_head = w_head_inc;
                            n_ptot = r_ptot - PW'(r_rd.pulses) + PW'(r_item.pulse_delta);
                            n_itot = r_itot - TW'(r_rd.interval) + TW'(w_ivl[IVL_W-1:0]);
                        end else begin
                            n_count = r_count + 1'b1;
                            n_ptot  = r_ptot + PW'(r_item.pulse_delta);
                            n_itot  = r_itot + TW'(w_ivl[IVL_W-1:0]);
                        end
                    end
                    n_last = r_item.sample_time;
                end
                n_state = S_TRIM_MUL;
            end
            S_TRIM_MUL: begin
                if (r_count > CW'(MIN_KEEP)) begin
                    n_prod     = MW'(w_p) * MW'(w_t);
                    n_too_long = LW'(r_count) > LW'(r_max_len);
                    n_state    = S_TRIM_CMP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_TRIM_CMP: begin
                if (r_too_long || w_fine) begin
                    n_head  = w_head_inc;
                    n_count = r_count - 1'b1;
                    n_ptot  = r_ptot - PW'(r_rd.pulses);
                    n_itot  = r_itot - TW'(r_rd.interval);
                    n_state = S_TRIM_MUL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.pulse_sum = r_ptot[PULSE_SUM_W-1:0];
                    n_out.time_sum  = r_itot[TIME_SUM_W-1:0];
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The read port follows the next head, so r_rd always holds the current oldest entry.
    // A write to that same slot is forwarded past the memory.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (w_we && (w_addr == n_head)) begin
            r_rd <= w_wdata;
        end else begin
            r_rd <= r_mem[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_ptot      <= '0;
            r_itot      <= '0;
            r_last      <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
            r_max_len   <= MAX_LEN_RST;
            r_max_delay <= MAX_DELAY_RST;
            r_res       <= RES_RST;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_ptot      <= n_ptot;
            r_itot      <= n_itot;
            r_last      <= n_last;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MAX_LENGTH: r_max_len   <= i_cfg_data[MAX_LEN_W-1:0];
                    CFG_MAX_DELAY:  r_max_delay <= i_cfg_data[MAX_DELAY_W-1:0];
                    CFG_RESOLUTION: r_res       <= i_cfg_data[RES_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_prod     <= n_prod;
        r_too_long <= n_too_long;
        r_out      <= n_out;
    end

endmodule
